/* hdl/mkpc_pkg.sv */
// Shared types and constants for the multi-key press classifier.
`default_nettype none
package mkpc_pkg;

    localparam int KEY_COUNT_DEFAULT = 8;
    localparam int MASK_WIDTH        = 8;
    localparam int CFG_DATA_WIDTH    = 16;
    localparam int CFG_INDEX_WIDTH   = 2;
    localparam int DEB_WIDTH         = 8;
    localparam int HOLD_WIDTH        = 16;
    localparam int FLAG_COUNT        = 6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FILTER_TICKS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_TICKS   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REPEAT_TICKS = 2'd2;

    localparam logic [DEB_WIDTH-1:0]  FILTER_TICKS_RESET = 8'd4;
    localparam logic [HOLD_WIDTH-1:0] LONG_TICKS_RESET   = 16'd100;
    localparam logic [HOLD_WIDTH-1:0] REPEAT_TICKS_RESET = 16'd20;

    typedef enum logic [1:0] {
        MODE_DEBOUNCE,
        MODE_PRESSED,
        MODE_LONG,
        MODE_REPEAT
    } key_mode_t;

    typedef struct packed {
        logic [DEB_WIDTH-1:0]  filter_ticks;
        logic [HOLD_WIDTH-1:0] long_ticks;
        logic [HOLD_WIDTH-1:0] repeat_ticks;
    } cfg_t;

    // Event flags of one key; long_ev and repeat_ev stay set until the key is released.
    typedef struct packed {
        logic repeat_ev;
        logic long_ev;
        logic release_click;
        logic press_click;
        logic down;
        logic up;
    } key_flags_t;

    localparam key_flags_t FLAGS_RESET = '{up: 1'b1, default: 1'b0};

endpackage
`default_nettype wire

/* hdl/mkpc_lane.sv */
// One key lane: debounce, pressed, long press and repeat state machine.
`default_nettype none
module mkpc_lane (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                update,
    input  wire logic                down,
    input  wire mkpc_pkg::cfg_t      cfg,
    output mkpc_pkg::key_flags_t     flags_next
);
    import mkpc_pkg::*;

    key_mode_t              mode_reg, mode_next;
    logic [DEB_WIDTH-1:0]   deb_reg, deb_next;
    logic [HOLD_WIDTH-1:0]  hold_reg, hold_next;
    logic [HOLD_WIDTH-1:0]  rep_reg, rep_next;
    key_flags_t             flags_reg;
    logic [HOLD_WIDTH-1:0]  hold_inc;
    logic [HOLD_WIDTH-1:0]  rep_inc;
    logic [DEB_WIDTH-1:0]   deb_inc;
    logic                   deb_done;
    logic                   hold_done;
    logic                   rep_done;

    assign deb_inc   = deb_reg + DEB_WIDTH'(1);
    assign hold_inc  = hold_reg + HOLD_WIDTH'(1);
    assign rep_inc   = rep_reg + HOLD_WIDTH'(1);
    assign deb_done  = deb_reg >= cfg.filter_ticks;
    assign hold_done = hold_inc >= cfg.long_ticks;
    assign rep_done  = rep_inc >= cfg.repeat_ticks;

    // Next state.
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_DEBOUNCE:
            begin
                if (down && deb_done)
                    mode_next = MODE_PRESSED;
            end
            MODE_PRESSED:
            begin
                mode_next = down ? MODE_LONG : MODE_DEBOUNCE;
            end
            MODE_LONG:
            begin
                if (!down)
                    mode_next = MODE_DEBOUNCE;
                else if (cfg.long_ticks != '0 && hold_done)
                    mode_next = MODE_REPEAT;
            end
            MODE_REPEAT:
            begin
                if (!down)
                    mode_next = MODE_DEBOUNCE;
            end
            default:
            begin
                mode_next = MODE_DEBOUNCE;
            end
        endcase
    end

    // Counters and flags.
    always_comb
    begin
        deb_next   = deb_reg;
        hold_next  = hold_reg;
        rep_next   = rep_reg;
        flags_next = flags_reg;
        case (mode_reg)
            MODE_DEBOUNCE:
            begin
                if (down)
                    deb_next = deb_done ? '0 : deb_inc;
                else
                begin
                    deb_next   = '0;
                    flags_next = FLAGS_RESET;
                end
                hold_next = '0;
                rep_next  = '0;
            end
            MODE_PRESSED:
            begin
                if (down)
                begin
                    flags_next.up          = 1'b0;
                    flags_next.down        = 1'b1;
                    flags_next.press_click = 1'b1;
                end
            end
            MODE_LONG:
            begin
                flags_next.press_click = 1'b0;
                if (!down)
                    flags_next.release_click = 1'b1;
                else if (cfg.long_ticks != '0)
                begin
                    hold_next = hold_inc;
                    if (hold_done)
                        flags_next.long_ev = 1'b1;
                end
            end
            MODE_REPEAT:
            begin
                if (down && cfg.repeat_ticks != '0)
                begin
                    if (rep_done)
                    begin
                        rep_next             = '0;
                        flags_next.repeat_ev = 1'b1;
                    end
                    else
                        rep_next = rep_inc;
                end
            end
            default:
            begin
                flags_next = flags_reg;
            end
        endcase
        if (!update)
        begin
            deb_next   = deb_reg;
            hold_next  = hold_reg;
            rep_next   = rep_reg;
            flags_next = flags_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_DEBOUNCE;
            deb_reg   <= '0;
            hold_reg  <= '0;
            rep_reg   <= '0;
            flags_reg <= FLAGS_RESET;
        end
        else if (update)
        begin
            mode_reg  <= mode_next;
            deb_reg   <= deb_next;
            hold_reg  <= hold_next;
            rep_reg   <= rep_next;
            flags_reg <= flags_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/mkpc_merge.sv */
// Gathers the lane flags into per-kind masks and holds the result beat.
`default_nettype none
module mkpc_merge #(
    parameter int KEY_COUNT = mkpc_pkg::KEY_COUNT_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic                              take,
    input  wire mkpc_pkg::key_flags_t [KEY_COUNT-1:0] lane_flags,
    output logic                                   valid,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]        up_mask,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]        down_mask,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]        click_down_mask,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]        click_up_mask,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]        long_mask,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]        repeat_mask
);
    import mkpc_pkg::*;

    key_flags_t [MASK_WIDTH-1:0] shown;
    logic                        valid_reg, valid_next;
    logic [MASK_WIDTH-1:0]       up_reg, down_reg, cdn_reg, cup_reg, long_reg, rep_reg;

    // Keys with no bit in the masks are left out.
    for (genvar k = 0; k < MASK_WIDTH; k++)
    begin : g_pick
        if (k < KEY_COUNT)
        begin : g_key
            assign shown[k] = lane_flags[k];
        end
        else
        begin : g_none
            assign shown[k] = '0;
        end
    end

    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < MASK_WIDTH; k++)
            begin
                up_reg[k]   <= shown[k].up;
                down_reg[k] <= shown[k].down;
                cdn_reg[k]  <= shown[k].press_click;
                cup_reg[k]  <= shown[k].release_click;
                long_reg[k] <= shown[k].long_ev;
                rep_reg[k]  <= shown[k].repeat_ev;
            end
        end
    end

    assign valid           = valid_reg;
    assign up_mask         = up_reg;
    assign down_mask       = down_reg;
    assign click_down_mask = cdn_reg;
    assign click_up_mask   = cup_reg;
    assign long_mask       = long_reg;
    assign repeat_mask     = rep_reg;

endmodule
`default_nettype wire

/* hdl/multi_key_press_classifier_core.sv */
// Top level of the multi-key press classifier: config registers, key lanes, merge.
//
// Usage: each input beat on in_valid/in_stall is one scan tick carrying the raw
// pressed level of every key in pressed_mask. Every input beat yields exactly one
// output beat on out_valid/out_stall carrying six masks: up, down, click down,
// click up, long press and repeat, bit n belonging to key n.
// Each key has its own lane with a four-state machine and its counters; all lanes
// update in parallel in the cycle the input beat is accepted, and the merge stage
// registers their flags into the masks. out_valid rises in the cycle after
// acceptance, and a new beat may be accepted every cycle while in_stall is low;
// out_valid comes from the single output register in the merge stage.
// When the receiver stalls with a result held, in_stall rises and the held beat
// stays unchanged until it is taken; the lanes do not advance meanwhile.
// Reset puts every key in the debounce state with only its up flag set, clears
// all counters and loads the register defaults: filter 4, long 100, repeat 20.
// The configuration port writes filter_ticks, long_ticks and repeat_ticks at
// indexes 0, 1 and 2; writes to other indexes are ignored. Write it while idle.
`default_nettype none
module multi_key_press_classifier_core #(
    parameter int KEY_COUNT = mkpc_pkg::KEY_COUNT_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [mkpc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [mkpc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [mkpc_pkg::MASK_WIDTH-1:0]       pressed_mask,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]            up_mask,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]            down_mask,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]            click_down_mask,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]            click_up_mask,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]            long_mask,
    output logic [mkpc_pkg::MASK_WIDTH-1:0]            repeat_mask
);
    import mkpc_pkg::*;

    cfg_t                        cfg_reg;
    logic                        in_accept;
    logic                        out_take;
    key_flags_t [KEY_COUNT-1:0]  lane_flags;

    // Configuration registers; an unknown index leaves them untouched.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_ticks <= FILTER_TICKS_RESET;
            cfg_reg.long_ticks   <= LONG_TICKS_RESET;
            cfg_reg.repeat_ticks <= REPEAT_TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_FILTER_TICKS: cfg_reg.filter_ticks <= cfg_data[DEB_WIDTH-1:0];
                CFG_LONG_TICKS:   cfg_reg.long_ticks   <= cfg_data[HOLD_WIDTH-1:0];
                CFG_REPEAT_TICKS: cfg_reg.repeat_ticks <= cfg_data[HOLD_WIDTH-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // The output register frees up in the same cycle its beat is taken, so the
    // input is held back only while a result sits stalled.
    assign in_stall  = out_valid && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;

    // One lane per key; keys without an input bit always read as released.
    for (genvar k = 0; k < KEY_COUNT; k++)
    begin : g_lane
        logic key_pressed;
        if (k < MASK_WIDTH)
        begin : g_in
            assign key_pressed = pressed_mask[k];
        end
        else
        begin : g_out
            assign key_pressed = 1'b0;
        end

        mkpc_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .update     (in_accept),
            .down       (key_pressed),
            .cfg        (cfg_reg),
            .flags_next (lane_flags[k])
        );
    end

    mkpc_merge #(
        .KEY_COUNT (KEY_COUNT)
    ) u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (in_accept),
        .take            (out_take),
        .lane_flags      (lane_flags),
        .valid           (out_valid),
        .up_mask         (up_mask),
        .down_mask       (down_mask),
        .click_down_mask (click_down_mask),
        .click_up_mask   (click_up_mask),
        .long_mask       (long_mask),
        .repeat_mask     (repeat_mask)
    );

    // Every accepted tick must produce a result beat in the next cycle.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted tick produced no result beat");

    // A key is never both up and down, and a click down only comes with down.
    a_up_down_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((up_mask & down_mask) == '0 &&
                       (click_down_mask & ~down_mask) == '0))
        else $error("up and down flags inconsistent");

    // Repeat implies long press, long press implies an accepted press, and a click up only comes with down.
    a_flag_nesting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((repeat_mask & ~long_mask) == '0 &&
                       (long_mask & ~down_mask) == '0 &&
                       (click_up_mask & ~down_mask) == '0))
        else $error("event flags out of order");

endmodule
`default_nettype wire
